>>> design/bbil_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbil_pkg: shared types and constants for the bike lights core
// Register indexes and field widths for the brake and indicator lamp logic.
// ----------------------------------------------------------------------------
package bbil_pkg;

  localparam int unsigned BrakeW    = 8;
  localparam int unsigned FlashW    = 12;
  localparam int unsigned HoldW     = 8;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 12;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    REG_BRAKE_PERIOD  = 3'd0,
    REG_BRAKE_IDLE_ON = 3'd1,
    REG_BRAKE_HELD_ON = 3'd2,
    REG_FLASH_PERIOD  = 3'd3,
    REG_FLASH_ON_LEN  = 3'd4,
    REG_RELEASE_HOLD  = 3'd5
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic [BrakeW-1:0] BRAKE_PERIOD_RST  = 8'd100;
  localparam logic [BrakeW-1:0] BRAKE_IDLE_ON_RST = 8'd40;
  localparam logic [BrakeW-1:0] BRAKE_HELD_ON_RST = 8'd90;
  localparam logic [FlashW-1:0] FLASH_PERIOD_RST  = 12'd600;
  localparam logic [FlashW-1:0] FLASH_ON_LEN_RST  = 12'd300;
  localparam logic [HoldW-1:0]  RELEASE_HOLD_RST  = 8'd100;

endpackage
`default_nettype wire

>>> design/bike_brake_and_indicator_lights_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bike_brake_and_indicator_lights_core: brake and indicator lamp controller
// Takes one millisecond tick request with three button levels per item and
// returns one lamp drive result per tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per tick, carrying brake_button, left_button and
//           right_button levels. Accepted when in_valid and in_ready are high.
//   out_* : one result per accepted request: brake_lamp, left_lamp,
//           right_lamp and sleep_request, held until out_ready.
//   cfg_* : register writes (cfg_index, cfg_data), always ready; write only
//           while no result is pending.
// The result appears in the cycle after acceptance. Throughput is one request
// per cycle while out_ready drains results; the tick state update and the
// lamp decision are one compare-and-count step feeding the result register.
// in_ready is high whenever the result register is empty or being drained,
// so a stalled receiver holds one result and blocks new requests only then.
// Reset clears all phases, release counters and flashing flags, loads the
// register defaults and empties the result register.
// ----------------------------------------------------------------------------
module bike_brake_and_indicator_lights_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // tick requests
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          brake_button,
  input  wire logic                          left_button,
  input  wire logic                          right_button,
  // lamp results
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               brake_lamp,
  output logic                               left_lamp,
  output logic                               right_lamp,
  output logic                               sleep_request,
  // register writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bbil_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [bbil_pkg::CfgDataW-1:0]  cfg_data
);

  // configuration registers
  logic [bbil_pkg::BrakeW-1:0] brake_period, brake_idle_on, brake_held_on;
  logic [bbil_pkg::FlashW-1:0] flash_period, flash_on_len;
  logic [bbil_pkg::HoldW-1:0]  release_hold;

  // tick state
  logic [bbil_pkg::BrakeW-1:0] brake_phase, brake_phase_next;
  logic [bbil_pkg::FlashW-1:0] flash_phase, flash_phase_next;
  logic [bbil_pkg::HoldW-1:0]  left_release_count, left_release_count_next;
  logic [bbil_pkg::HoldW-1:0]  right_release_count, right_release_count_next;
  logic                        left_flashing, left_flashing_next;
  logic                        right_flashing, right_flashing_next;

  // per-tick working values
  logic                        in_fire, sleep_tick;
  logic                        left_press, right_press;
  logic                        lf_mid, rf_mid;
  logic                        lf_post, rf_post;
  logic                        any_press;
  logic [bbil_pkg::FlashW-1:0] fphase_post;
  logic [bbil_pkg::BrakeW:0]   brake_inc;
  logic [bbil_pkg::FlashW:0]   flash_inc;
  logic                        brake_on, flash_on;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign sleep_tick = left_button && right_button;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      brake_period  <= bbil_pkg::BRAKE_PERIOD_RST;
      brake_idle_on <= bbil_pkg::BRAKE_IDLE_ON_RST;
      brake_held_on <= bbil_pkg::BRAKE_HELD_ON_RST;
      flash_period  <= bbil_pkg::FLASH_PERIOD_RST;
      flash_on_len  <= bbil_pkg::FLASH_ON_LEN_RST;
      release_hold  <= bbil_pkg::RELEASE_HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bbil_pkg::REG_BRAKE_PERIOD:  brake_period  <= cfg_data[bbil_pkg::BrakeW-1:0];
        bbil_pkg::REG_BRAKE_IDLE_ON: brake_idle_on <= cfg_data[bbil_pkg::BrakeW-1:0];
        bbil_pkg::REG_BRAKE_HELD_ON: brake_held_on <= cfg_data[bbil_pkg::BrakeW-1:0];
        bbil_pkg::REG_FLASH_PERIOD:  flash_period  <= cfg_data;
        bbil_pkg::REG_FLASH_ON_LEN:  flash_on_len  <= cfg_data;
        bbil_pkg::REG_RELEASE_HOLD:  release_hold  <= cfg_data[bbil_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  // brake lamp from the phase before it advances
  always_comb begin
    brake_on  = (brake_button && (brake_phase < brake_held_on)) ||
                (brake_phase < brake_idle_on);
    brake_inc = {1'b0, brake_phase} + {{bbil_pkg::BrakeW{1'b0}}, 1'b1};
    if (brake_inc >= {1'b0, brake_period}) begin
      brake_phase_next = '0;
    end else begin
      brake_phase_next = brake_inc[bbil_pkg::BrakeW-1:0];
    end
  end

  // press detection, left handled before right
  always_comb begin
    left_press  = left_button && (left_release_count == '0);
    right_press = right_button && (right_release_count == '0);

    lf_mid = left_flashing;
    rf_mid = right_flashing;
    if (left_press) begin
      if (left_flashing || right_flashing) begin
        lf_mid = 1'b0;
        rf_mid = 1'b0;
      end else begin
        lf_mid = 1'b1;
      end
    end

    lf_post = lf_mid;
    rf_post = rf_mid;
    if (right_press) begin
      if (lf_mid || rf_mid) begin
        lf_post = 1'b0;
        rf_post = 1'b0;
      end else begin
        rf_post = 1'b1;
      end
    end

    any_press   = left_press || right_press;
    fphase_post = any_press ? '0 : flash_phase;
  end

  // release counters
  always_comb begin
    left_release_count_next = left_release_count;
    if (left_press) begin
      left_release_count_next = release_hold;
    end else if (!left_button && (left_release_count != '0)) begin
      left_release_count_next = left_release_count - {{(bbil_pkg::HoldW-1){1'b0}}, 1'b1};
    end

    right_release_count_next = right_release_count;
    if (right_press) begin
      right_release_count_next = release_hold;
    end else if (!right_button && (right_release_count != '0)) begin
      right_release_count_next = right_release_count - {{(bbil_pkg::HoldW-1){1'b0}}, 1'b1};
    end
  end

  // indicator lamps and flash phase advance
  always_comb begin
    flash_on  = fphase_post < flash_on_len;
    flash_inc = {1'b0, fphase_post} + {{bbil_pkg::FlashW{1'b0}}, 1'b1};
    flash_phase_next = fphase_post;
    if (lf_post || rf_post) begin
      if (flash_inc >= {1'b0, flash_period}) begin
        flash_phase_next = '0;
      end else begin
        flash_phase_next = flash_inc[bbil_pkg::FlashW-1:0];
      end
    end
    left_flashing_next  = lf_post;
    right_flashing_next = rf_post;
  end

  // tick state, left untouched on a sleep tick
  always_ff @(posedge clk) begin
    if (rst) begin
      brake_phase         <= '0;
      flash_phase         <= '0;
      left_release_count  <= '0;
      right_release_count <= '0;
      left_flashing       <= 1'b0;
      right_flashing      <= 1'b0;
    end else if (in_fire && !sleep_tick) begin
      brake_phase         <= brake_phase_next;
      flash_phase         <= flash_phase_next;
      left_release_count  <= left_release_count_next;
      right_release_count <= right_release_count_next;
      left_flashing       <= left_flashing_next;
      right_flashing      <= right_flashing_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (sleep_tick) begin
        brake_lamp    <= 1'b0;
        left_lamp     <= 1'b1;
        right_lamp    <= 1'b1;
        sleep_request <= 1'b1;
      end else begin
        brake_lamp    <= brake_on;
        left_lamp     <= lf_post && flash_on;
        right_lamp    <= rf_post && flash_on;
        sleep_request <= 1'b0;
      end
    end
  end

  // at most one side flashes at a time
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(left_flashing && right_flashing))
    else $error("both indicator sides flashing");

  // a sleep tick leaves the tick state alone
  a_sleep_hold: assert property (@(posedge clk) disable iff (rst)
    (in_fire && sleep_tick) |=> ($stable(brake_phase) && $stable(flash_phase) &&
      $stable(left_flashing) && $stable(right_flashing)))
    else $error("tick state changed on a sleep tick");

  // a sleep tick yields the sleep pattern
  a_sleep_out: assert property (@(posedge clk) disable iff (rst)
    (in_fire && sleep_tick) |=> (out_valid && sleep_request && !brake_lamp &&
      left_lamp && right_lamp))
    else $error("wrong result for a sleep tick");

  // a lit indicator on a normal tick means its side is flashing
  a_lit_flashing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !sleep_request) |-> ((!left_lamp || left_flashing) &&
      (!right_lamp || right_flashing)))
    else $error("indicator lit while its side is not flashing");

endmodule
`default_nettype wire

>>> bench/bike_brake_and_indicator_lights_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bike_brake_and_indicator_lights_core_test: self-checking bench for the core
// Sends tick requests with button levels through a directed script and then
// through random phases under several register settings. Every lamp result is
// compared with an in-bench lamp predictor, or with a typed expectation on
// some script rows. Both handshakes are stalled at random.
// ----------------------------------------------------------------------------
module bike_brake_and_indicator_lights_core_test;

  localparam int unsigned BrakeW   = bbil_pkg::BrakeW;
  localparam int unsigned FlashW   = bbil_pkg::FlashW;
  localparam int unsigned HoldW    = bbil_pkg::HoldW;
  localparam int unsigned CfgDataW = bbil_pkg::CfgDataW;

  localparam int unsigned RAND_PHASES     = 9;
  localparam int unsigned ITEMS_PER_PHASE = 120;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned END_SLACK       = 4;

  // one lamp result, msb first: brake, left, right, sleep
  typedef struct packed {
    logic brake_lamp;
    logic left_lamp;
    logic right_lamp;
    logic sleep_request;
  } lamps_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  // directed script row: a tick request or a register write
  typedef struct packed {
    row_kind_t             kind;
    bbil_pkg::cfg_reg_t    reg_idx;
    logic [CfgDataW-1:0]   data;
    logic [2:0]            buttons;  // {brake, left, right}
    logic                  typed;
    lamps_t                want;
  } script_row_t;

  localparam lamps_t NO_LAMPS    = '0;
  localparam lamps_t FIRST_LAMPS = '{brake_lamp: 1'b1, left_lamp: 1'b0,
                                     right_lamp: 1'b0, sleep_request: 1'b0};
  localparam lamps_t SLEEP_LAMPS = '{brake_lamp: 1'b0, left_lamp: 1'b1,
                                     right_lamp: 1'b1, sleep_request: 1'b1};
  localparam int unsigned SCRIPT_LEN = 35;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic                brake_button  = 1'b0;
  logic                left_button   = 1'b0;
  logic                right_button  = 1'b0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic                brake_lamp;
  logic                left_lamp;
  logic                right_lamp;
  logic                sleep_request;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  bbil_pkg::cfg_reg_t  cfg_index     = bbil_pkg::REG_BRAKE_PERIOD;
  logic [CfgDataW-1:0] cfg_data      = '0;

  // idle odds in percent for each side
  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 78;

  // predictor copy of the registers
  logic [BrakeW-1:0] brake_len     = bbil_pkg::BRAKE_PERIOD_RST;
  logic [BrakeW-1:0] brake_idle_on = bbil_pkg::BRAKE_IDLE_ON_RST;
  logic [BrakeW-1:0] brake_held_on = bbil_pkg::BRAKE_HELD_ON_RST;
  logic [FlashW-1:0] flash_len     = bbil_pkg::FLASH_PERIOD_RST;
  logic [FlashW-1:0] flash_on      = bbil_pkg::FLASH_ON_LEN_RST;
  logic [HoldW-1:0]  hold_ticks    = bbil_pkg::RELEASE_HOLD_RST;

  // predictor copy of the tick state
  logic [BrakeW-1:0] brake_tick     = '0;
  logic [FlashW-1:0] flash_tick     = '0;
  logic [HoldW-1:0]  left_lockout   = '0;
  logic [HoldW-1:0]  right_lockout  = '0;
  logic              left_blinking  = 1'b0;
  logic              right_blinking = 1'b0;

  lamps_t lamps_due [$];

  int unsigned ticks_sent     = 0;
  int unsigned lamps_checked  = 0;
  int unsigned sleep_ticks    = 0;
  int unsigned left_presses   = 0;
  int unsigned right_presses  = 0;
  int unsigned writes_done    = 0;
  int unsigned mismatch_count = 0;

  // field names by bit position of lamps_t
  string lamp_field [4] = '{"sleep_request", "right_lamp", "left_lamp", "brake_lamp"};

  // directed script: reset values, sleep, presses, zero and full registers
  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b000, 1'b1, FIRST_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b100, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b011, 1'b1, SLEEP_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b111, 1'b1, SLEEP_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b010, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b001, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_RELEASE_HOLD,  12'd0,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_FLASH_PERIOD,  12'd2,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_FLASH_ON_LEN,  12'd1,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b010, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b010, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b010, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b110, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_BRAKE_IDLE_ON, 12'd0,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_BRAKE_HELD_ON, 12'd0,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b100, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_BRAKE_PERIOD,  12'd255,  3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_BRAKE_IDLE_ON, 12'd255,  3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_BRAKE_HELD_ON, 12'd255,  3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_FLASH_PERIOD,  12'd4095, 3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_FLASH_ON_LEN,  12'd4095, 3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_RELEASE_HOLD,  12'd255,  3'b000, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b101, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b001, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_FLASH_ON_LEN,  12'd0,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_WRITE, bbil_pkg::REG_RELEASE_HOLD,  12'd1,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b010, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b000, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b010, 1'b0, NO_LAMPS},
    '{ROW_TICK,  bbil_pkg::REG_BRAKE_PERIOD,  12'd0,    3'b000, 1'b0, NO_LAMPS}
  };

  bike_brake_and_indicator_lights_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .brake_button  (brake_button),
    .left_button   (left_button),
    .right_button  (right_button),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .brake_lamp    (brake_lamp),
    .left_lamp     (left_lamp),
    .right_lamp    (right_lamp),
    .sleep_request (sleep_request),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // a counted press restarts the flash and toggles flashing
  function automatic void register_press(input logic is_left);
    flash_tick = '0;
    if (is_left) left_presses++;
    else right_presses++;
    if (left_blinking || right_blinking) begin
      left_blinking  = 1'b0;
      right_blinking = 1'b0;
    end else if (is_left) begin
      left_blinking = 1'b1;
    end else begin
      right_blinking = 1'b1;
    end
  endfunction

  // release lockout: a press counts only once the lockout has run out
  function automatic logic debounce_press(input logic level,
                                          inout logic [HoldW-1:0] lockout);
    if (level && lockout == '0) begin
      lockout = hold_ticks;
      return 1'b1;
    end
    if (!level && lockout != '0) lockout = lockout - {{(HoldW-1){1'b0}}, 1'b1};
    return 1'b0;
  endfunction

  // lamps for one tick, advancing the predictor state
  function automatic lamps_t predict_lamps(input logic [2:0] buttons);
    lamps_t            lamps;
    logic [BrakeW:0]   brake_next;
    logic [FlashW:0]   flash_next;
    lamps = '0;
    if (buttons[1] && buttons[0]) begin
      lamps.left_lamp     = 1'b1;
      lamps.right_lamp    = 1'b1;
      lamps.sleep_request = 1'b1;
      return lamps;
    end
    lamps.brake_lamp = (buttons[2] && brake_tick < brake_held_on) ||
                       brake_tick < brake_idle_on;
    brake_next = {1'b0, brake_tick} + {{BrakeW{1'b0}}, 1'b1};
    brake_tick = (brake_next >= {1'b0, brake_len}) ? '0 : brake_next[BrakeW-1:0];
    if (debounce_press(buttons[1], left_lockout)) register_press(1'b1);
    if (debounce_press(buttons[0], right_lockout)) register_press(1'b0);
    lamps.left_lamp  = left_blinking && flash_tick < flash_on;
    lamps.right_lamp = right_blinking && flash_tick < flash_on;
    if (left_blinking || right_blinking) begin
      flash_next = {1'b0, flash_tick} + {{FlashW{1'b0}}, 1'b1};
      flash_tick = (flash_next >= {1'b0, flash_len}) ? '0 : flash_next[FlashW-1:0];
    end
    return lamps;
  endfunction

  // one tick request; the expectation is queued when it is accepted
  task automatic send_tick(input logic [2:0] buttons, input logic typed,
                           input lamps_t typed_lamps);
    lamps_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {brake_button, left_button, right_button} <= buttons;
    do @(posedge clk); while (!in_ready);
    predicted = predict_lamps(buttons);
    lamps_due.push_back(typed ? typed_lamps : predicted);
    ticks_sent++;
  endtask

  // register write; the caller lowers cfg_valid after the last one
  task automatic write_register(input bbil_pkg::cfg_reg_t idx,
                                input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bbil_pkg::REG_BRAKE_PERIOD:  brake_len     = value[BrakeW-1:0];
      bbil_pkg::REG_BRAKE_IDLE_ON: brake_idle_on = value[BrakeW-1:0];
      bbil_pkg::REG_BRAKE_HELD_ON: brake_held_on = value[BrakeW-1:0];
      bbil_pkg::REG_FLASH_PERIOD:  flash_len     = value[FlashW-1:0];
      bbil_pkg::REG_FLASH_ON_LEN:  flash_on      = value[FlashW-1:0];
      bbil_pkg::REG_RELEASE_HOLD:  hold_ticks    = value[HoldW-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // stop requests and wait for every queued result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (lamps_due.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // result checker
  always @(posedge clk) begin : check_lamps
    lamps_t seen;
    lamps_t due;
    if (!rst && out_valid && out_ready) begin
      seen = {brake_lamp, left_lamp, right_lamp, sleep_request};
      if (lamps_due.size() == 0) begin
        $error("unexpected result %b with nothing pending", seen);
        mismatch_count++;
      end else begin
        due = lamps_due.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (seen[f] !== due[f]) begin
            $error("%s: expected %0b, got %0b", lamp_field[f], due[f], seen[f]);
            mismatch_count++;
          end
        end
        lamps_checked++;
        if (due.sleep_request) sleep_ticks++;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[bike_brake_and_indicator_lights_core] ERROR");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic              prev_write;
    logic [2:0]        buttons;
    logic [2:0]        level;
    int unsigned       run [3];
    logic [BrakeW-1:0] bp, bd, bs;
    logic [FlashW-1:0] fp, fd;
    logic [HoldW-1:0]  rh;
    level = '0;
    for (int k = 0; k < 3; k++) run[k] = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed script
    prev_write = 1'b0;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (!prev_write) drain_results();
        write_register(script[i].reg_idx, script[i].data);
        prev_write = 1'b1;
      end else begin
        if (prev_write) cfg_valid <= 1'b0;
        send_tick(script[i].buttons, script[i].typed, script[i].want);
        prev_write = 1'b0;
      end
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase / 3)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      case (phase)
        0: begin
          bp = 8'd10;  bd = 8'd3;  bs = 8'd7;  fp = 12'd20;  fd = 12'd8;  rh = 8'd4;
        end
        1: begin
          bp = 8'd255; bd = 8'd255; bs = 8'd255; fp = 12'd4095; fd = 12'd4095;
          rh = 8'd255;
        end
        2: begin
          bp = '0; bd = '0; bs = '0; fp = '0; fd = '0; rh = '0;
        end
        default: begin
          if ($urandom_range(3) == 0) begin
            bp = BrakeW'($urandom);
            bd = BrakeW'($urandom);
            bs = BrakeW'($urandom);
            fp = FlashW'($urandom);
            fd = FlashW'($urandom);
            rh = HoldW'($urandom_range(0, 40));
          end else begin
            bp = BrakeW'($urandom_range(1, 40));
            bd = BrakeW'($urandom_range(0, bp + 2));
            bs = BrakeW'($urandom_range(0, bp + 2));
            fp = FlashW'($urandom_range(1, 60));
            fd = FlashW'($urandom_range(0, fp + 2));
            rh = HoldW'($urandom_range(0, 12));
          end
        end
      endcase

      drain_results();
      write_register(bbil_pkg::REG_BRAKE_PERIOD,  CfgDataW'(bp));
      write_register(bbil_pkg::REG_BRAKE_IDLE_ON, CfgDataW'(bd));
      write_register(bbil_pkg::REG_BRAKE_HELD_ON, CfgDataW'(bs));
      write_register(bbil_pkg::REG_FLASH_PERIOD,  fp);
      write_register(bbil_pkg::REG_FLASH_ON_LEN,  fd);
      write_register(bbil_pkg::REG_RELEASE_HOLD,  CfgDataW'(rh));
      cfg_valid <= 1'b0;

      // button runs: short presses, releases around the lockout, some noise
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(9) == 0) begin
          buttons = 3'($urandom);
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (run[k] == 0) begin
              level[k] = ~level[k];
              if (k == 2) run[k] = $urandom_range(1, 30);
              else if (level[k]) run[k] = $urandom_range(1, 5);
              else run[k] = $urandom_range(1, int'(hold_ticks) + 4);
            end
            run[k]--;
          end
          buttons = level;
        end
        send_tick(buttons, 1'b0, NO_LAMPS);
      end
    end

    drain_results();
    repeat (END_SLACK) @(posedge clk);

    $display("covered %0d tick requests, %0d results checked, %0d register writes",
             ticks_sent, lamps_checked, writes_done);
    $display("indicator presses counted: %0d left, %0d right; sleep ticks: %0d",
             left_presses, right_presses, sleep_ticks);
    if (mismatch_count == 0)
      $display("[bike_brake_and_indicator_lights_core] OK");
    else
      $display("[bike_brake_and_indicator_lights_core] ERROR");
    $finish;
  end

endmodule

>>> sim.f
design/bbil_pkg.sv
design/bike_brake_and_indicator_lights_core.sv
bench/bike_brake_and_indicator_lights_core_test.sv
